@@ src/mbm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbm_pkg: shared types and constants
// Sizes of the banked word memory and the command that travels from the
// front end to the back end.
// ----------------------------------------------------------------------------
package mbm_pkg;

  localparam int MEM_WORDS  = 1024;                 // power of two, at least 2
  localparam int MEM_AW     = $clog2(MEM_WORDS);
  localparam int BANK_WORDS = MEM_WORDS / 2;        // even and odd word banks
  localparam int BANK_AW    = MEM_AW - 1;

  localparam int ADDR_W     = 12;
  localparam int WORD_IDX_W = ADDR_W - 2;
  localparam int DATA_W     = 32;
  localparam int MASK_W     = 4;
  localparam int LANE_W     = 8;

  localparam int RES_DEPTH  = 4;
  localparam int RES_PW     = $clog2(RES_DEPTH);
  localparam int RES_CW     = $clog2(RES_DEPTH + 1);

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic                 wr;
    logic [BANK_AW-1:0]   even_idx;
    logic [BANK_AW-1:0]   odd_idx;
    logic [MASK_W-1:0]    even_be;
    logic [MASK_W-1:0]    odd_be;
    logic [DATA_W-1:0]    even_data;
    logic [DATA_W-1:0]    odd_data;
    logic                 swap;     // first word sits in the odd bank
    logic [1:0]           off;      // byte offset in the first word
  } cmd_t;

endpackage

@@ src/mbm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbm_front: access classifier
// Accepts accesses, splits the byte address into bank indexes and shifts the
// write data and byte mask onto the even and odd banks.
// ----------------------------------------------------------------------------
module mbm_front
  import mbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_op,
  input  logic [ADDR_W-1:0] in_addr,
  input  logic [DATA_W-1:0] in_write_data,
  input  logic [MASK_W-1:0] in_byte_mask,
  input  logic              clearing,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic                  vld_r;
  cmd_t                  cmd_r;
  cmd_t                  cmd_nxt;
  logic                  accept;
  logic [MEM_AW-1:0]     w0;
  logic [2*DATA_W-1:0]   d64;
  logic [2*MASK_W-1:0]   m8;
  logic [MASK_W-1:0]     be_in;

  assign q_push  = vld_r && !q_full;
  assign in_full = clearing || (vld_r && q_full);
  assign accept  = in_push && !in_full;
  assign q_cmd   = cmd_r;

  always_comb begin
    w0    = MEM_AW'(in_addr[ADDR_W-1:2]);
    be_in = (in_op == OP_WRITE) ? in_byte_mask : '0;
    d64   = {{DATA_W{1'b0}}, in_write_data} << {in_addr[1:0], 3'b000};
    m8    = {{MASK_W{1'b0}}, be_in} << in_addr[1:0];

    cmd_nxt.wr       = (in_op == OP_WRITE);
    cmd_nxt.swap     = w0[0];
    cmd_nxt.off      = in_addr[1:0];
    // odd first word: its successor is the next row of the even bank
    cmd_nxt.even_idx = w0[MEM_AW-1:1] + BANK_AW'(w0[0]);
    cmd_nxt.odd_idx  = w0[MEM_AW-1:1];
    if (w0[0]) begin
      cmd_nxt.odd_data  = d64[DATA_W-1:0];
      cmd_nxt.odd_be    = m8[MASK_W-1:0];
      cmd_nxt.even_data = d64[2*DATA_W-1:DATA_W];
      cmd_nxt.even_be   = m8[2*MASK_W-1:MASK_W];
    end else begin
      cmd_nxt.even_data = d64[DATA_W-1:0];
      cmd_nxt.even_be   = m8[MASK_W-1:0];
      cmd_nxt.odd_data  = d64[2*DATA_W-1:DATA_W];
      cmd_nxt.odd_be    = m8[2*MASK_W-1:MASK_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (accept) begin
      vld_r <= 1'b1;
    end else if (q_push) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

@@ src/mbm_cmd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbm_cmd_queue: two-entry command queue
// Decouples the classifier from the memory back end.
// ----------------------------------------------------------------------------
module mbm_cmd_queue
  import mbm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ src/mbm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbm_back: banked memory and result queue
// Runs commands on the even and odd word banks, clears them after reset and
// aligns read data into a small result queue.
// ----------------------------------------------------------------------------
module mbm_back
  import mbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_vld,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  output logic              clearing,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [DATA_W-1:0] out_read_data
);

  logic [DATA_W-1:0]   even_mem [BANK_WORDS];
  logic [DATA_W-1:0]   odd_mem  [BANK_WORDS];

  logic                clr_r;
  logic [BANK_AW-1:0]  clr_idx_r;

  logic                issue;
  logic                ev_we;
  logic                od_we;
  logic [BANK_AW-1:0]  ev_idx;
  logic [BANK_AW-1:0]  od_idx;
  logic [MASK_W-1:0]   ev_be;
  logic [MASK_W-1:0]   od_be;
  logic [DATA_W-1:0]   ev_wd;
  logic [DATA_W-1:0]   od_wd;

  logic [DATA_W-1:0]   even_rd_r;
  logic [DATA_W-1:0]   odd_rd_r;
  logic                b_vld_r;
  logic                b_wr_r;
  logic                b_swap_r;
  logic [1:0]          b_off_r;
  logic [2*DATA_W-1:0] pair;
  logic [DATA_W-1:0]   aligned;

  logic [DATA_W-1:0]   res_r [RES_DEPTH];
  logic [RES_PW-1:0]   res_wr_ptr_r;
  logic [RES_PW-1:0]   res_rd_ptr_r;
  logic [RES_CW-1:0]   res_cnt_r;
  logic [RES_CW-1:0]   res_cnt_nxt;
  logic                res_pop;

  assign clearing = clr_r;

  // issue only when the result queue has a slot for this and the one in flight
  assign issue   = cmd_vld && !clr_r &&
                   ((res_cnt_r + RES_CW'(b_vld_r)) < RES_CW'(RES_DEPTH));
  assign cmd_pop = issue;

  always_comb begin
    ev_idx = clr_r ? clr_idx_r : cmd.even_idx;
    od_idx = clr_r ? clr_idx_r : cmd.odd_idx;
    ev_be  = clr_r ? {MASK_W{1'b1}} : cmd.even_be;
    od_be  = clr_r ? {MASK_W{1'b1}} : cmd.odd_be;
    ev_wd  = clr_r ? '0 : cmd.even_data;
    od_wd  = clr_r ? '0 : cmd.odd_data;
    ev_we  = clr_r || (issue && cmd.wr);
    od_we  = clr_r || (issue && cmd.wr);
  end

  // clearing pass: one row of each bank per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + BANK_AW'(1);
      if (clr_idx_r == BANK_AW'(BANK_WORDS - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_we) begin
      for (int b = 0; b < MASK_W; b++) begin
        if (ev_be[b]) begin
          even_mem[ev_idx][b*LANE_W +: LANE_W] <= ev_wd[b*LANE_W +: LANE_W];
        end
      end
    end
    if (issue && !cmd.wr) begin
      even_rd_r <= even_mem[ev_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (od_we) begin
      for (int b = 0; b < MASK_W; b++) begin
        if (od_be[b]) begin
          odd_mem[od_idx][b*LANE_W +: LANE_W] <= od_wd[b*LANE_W +: LANE_W];
        end
      end
    end
    if (issue && !cmd.wr) begin
      odd_rd_r <= odd_mem[od_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_wr_r   <= cmd.wr;
      b_swap_r <= cmd.swap;
      b_off_r  <= cmd.off;
    end
  end

  // merge first word (low) with its successor (high), then drop offset bytes
  always_comb begin
    pair    = b_swap_r ? {even_rd_r, odd_rd_r} : {odd_rd_r, even_rd_r};
    aligned = b_wr_r ? '0 : DATA_W'(pair >> {b_off_r, 3'b000});
  end

  assign res_pop       = out_pop && !out_empty;
  assign out_empty     = (res_cnt_r == '0);
  assign out_read_data = res_r[res_rd_ptr_r];

  always_comb begin
    res_cnt_nxt = res_cnt_r;
    if (b_vld_r && !res_pop) begin
      res_cnt_nxt = res_cnt_r + RES_CW'(1);
    end else if (res_pop && !b_vld_r) begin
      res_cnt_nxt = res_cnt_r - RES_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_ptr_r <= '0;
      res_rd_ptr_r <= '0;
      res_cnt_r    <= '0;
    end else begin
      if (b_vld_r) begin
        res_wr_ptr_r <= res_wr_ptr_r + RES_PW'(1);
      end
      if (res_pop) begin
        res_rd_ptr_r <= res_rd_ptr_r + RES_PW'(1);
      end
      res_cnt_r <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld_r) begin
      res_r[res_wr_ptr_r] <= aligned;
    end
  end

endmodule

@@ src/misaligned_byte_mask_word_memory.sv @@
`timescale 1ns / 1ps
// An access passes the command register, command queue, bank read, result queue.
// Throughput: one access per cycle while results are popped; the even/odd word
//   banks serve both words of a misaligned access in the same cycle.
// Reset: after rst_n is released, a clearing pass zeroes one row of each bank per
//   cycle until all MEM_WORDS/2 (512) rows are zero, with in_full held high meanwhile.
// ----------------------------------------------------------------------------
// misaligned_byte_mask_word_memory: byte-addressed word memory
// Serves 32-bit reads and byte-masked writes at any byte alignment. A front
// end classifies each transaction into even and odd bank commands, a short
// command queue decouples it from the back end, which owns the two banks,
// aligns read data and buffers results in a small queue.
// ----------------------------------------------------------------------------
module misaligned_byte_mask_word_memory
  import mbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_op,
  input  logic [ADDR_W-1:0] in_addr,
  input  logic [DATA_W-1:0] in_write_data,
  input  logic [MASK_W-1:0] in_byte_mask,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [DATA_W-1:0] out_read_data
);

  logic clearing;
  logic q_push;
  logic q_full;
  logic q_empty;
  logic q_pop;
  cmd_t q_in_cmd;
  cmd_t q_head;

  // front end: accept the transaction and split it onto the two banks
  mbm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_addr       (in_addr),
    .in_write_data (in_write_data),
    .in_byte_mask  (in_byte_mask),
    .clearing      (clearing),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_in_cmd)
  );

  // hold commands while the back end waits on result space
  mbm_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // back end: clear after reset, then run reads and writes in order
  mbm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_vld       (!q_empty),
    .cmd           (q_head),
    .cmd_pop       (q_pop),
    .clearing      (clearing),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_read_data (out_read_data)
  );

`ifndef SYNTHESIS
  // the clearing pass must start right after reset with the input blocked
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !$past(rst_n)) |-> (clearing && in_full))
    else $error("clearing pass not active after reset");

  // no command may be waiting while the banks are being cleared
  a_queue_idle_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (q_empty && !q_push))
    else $error("command pending during clearing pass");

  // no result may appear before the clearing pass is over
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> out_empty)
    else $error("result produced during clearing pass");
`endif

endmodule

@@ verif/mbm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbm_checker: prediction and checking for the misaligned word memory
// Watches both queue-style channels. Keeps its own image of the word store and
// predicts the read data of every accepted transaction. Compares each popped
// result with the oldest prediction.
// ----------------------------------------------------------------------------
module mbm_checker
  import mbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_full,
  input  logic              in_op,
  input  logic [ADDR_W-1:0] in_addr,
  input  logic [DATA_W-1:0] in_write_data,
  input  logic [MASK_W-1:0] in_byte_mask,
  input  logic              out_empty,
  input  logic              out_pop,
  input  logic [DATA_W-1:0] out_read_data,
  output int                mismatch_count,
  output int                results_owed
);

  logic [DATA_W-1:0] word_image [MEM_WORDS];
  logic [DATA_W-1:0] expected_read_data [$];
  logic [DATA_W-1:0] oldest;
  int                mismatches;

  // Apply one access to the image and return its read data (zero for a write).
  function automatic logic [DATA_W-1:0] apply_access(
    input logic              op,
    input logic [ADDR_W-1:0] addr,
    input logic [DATA_W-1:0] wdata,
    input logic [MASK_W-1:0] mask
  );
    int unsigned         lo_idx;
    int unsigned         hi_idx;
    int unsigned         shift;
    logic [2*DATA_W-1:0] pair;
    logic [2*DATA_W-1:0] lanes;
    logic [2*DATA_W-1:0] shifted;
    lo_idx = (addr >> 2) % MEM_WORDS;
    hi_idx = (lo_idx + 1) % MEM_WORDS;
    shift  = addr[1:0] * LANE_W;
    if (op == OP_READ) begin
      pair = {word_image[hi_idx], word_image[lo_idx]};
      pair = pair >> shift;
      return pair[DATA_W-1:0];
    end
    lanes = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (mask[i]) lanes[i*LANE_W +: LANE_W] = '1;
    end
    lanes   = lanes << shift;
    shifted = {{DATA_W{1'b0}}, wdata} << shift;
    word_image[lo_idx] = (word_image[lo_idx] & ~lanes[DATA_W-1:0]) |
                         (shifted[DATA_W-1:0] & lanes[DATA_W-1:0]);
    // the second word is touched only when some enabled byte spills into it
    if (lanes[2*DATA_W-1:DATA_W] != '0) begin
      word_image[hi_idx] = (word_image[hi_idx] & ~lanes[2*DATA_W-1:DATA_W]) |
                           (shifted[2*DATA_W-1:DATA_W] & lanes[2*DATA_W-1:DATA_W]);
    end
    return '0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (word_image[i]) word_image[i] = '0;
      expected_read_data.delete();
      mismatches = 0;
    end else begin
      // a result popped now is older than any transaction accepted now
      if (out_pop && !out_empty) begin
        if (expected_read_data.size() == 0) begin
          $error("unexpected result: read_data %h with nothing pending", out_read_data);
          mismatches++;
        end else begin
          oldest = expected_read_data.pop_front();
          if (out_read_data !== oldest) begin
            $error("read_data mismatch: expected %h, actual %h", oldest, out_read_data);
            mismatches++;
          end
        end
      end
      if (in_push && !in_full) begin
        expected_read_data.push_back(
          apply_access(in_op, in_addr, in_write_data, in_byte_mask));
      end
    end
    mismatch_count <= mismatches;
    results_owed   <= expected_read_data.size();
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top of the misaligned word memory testbench
// Drives byte-addressed reads and byte-masked writes at every alignment, with
// random gaps on both channels, and leaves prediction and comparison to the
// checker instantiated beside the memory.
// ----------------------------------------------------------------------------
module tb;
  import mbm_pkg::*;

  // cycles in a row in which neither channel moves a transaction before the run is
  // abandoned; covers the clearing pass after reset with a wide margin
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 550;
  localparam int TAIL_CYCLES  = 12;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic              in_op = OP_READ;
  logic [ADDR_W-1:0] in_addr = '0;
  logic [DATA_W-1:0] in_write_data = '0;
  logic [MASK_W-1:0] in_byte_mask = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [DATA_W-1:0] out_read_data;

  int                mismatch_count;
  int                results_owed;
  int                quiet_cycles;
  // set during a stretch where neither side inserts gaps
  logic              steady_flow = 1'b0;

  always #5 clk = ~clk;

  misaligned_byte_mask_word_memory dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_addr       (in_addr),
    .in_write_data (in_write_data),
    .in_byte_mask  (in_byte_mask),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_read_data (out_read_data)
  );

  mbm_checker access_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_op          (in_op),
    .in_addr        (in_addr),
    .in_write_data  (in_write_data),
    .in_byte_mask   (in_byte_mask),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_read_data  (out_read_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // Pop side: stall with a chance of roughly 27 in a hundred, never while steady.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= steady_flow || ($urandom_range(99) >= 27);
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one transaction, maybe after a short gap, and hold it until the
  // memory takes it. Called at a rising edge; returns at the accepting edge
  // with push still high, so the next call can follow back to back.
  task automatic issue_access(
    input logic              op,
    input logic [ADDR_W-1:0] addr,
    input logic [DATA_W-1:0] wdata,
    input logic [MASK_W-1:0] mask
  );
    if (!steady_flow && $urandom_range(99) < 27) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_op         <= op;
    in_addr       <= addr;
    in_write_data <= wdata;
    in_byte_mask  <= mask;
    do @(posedge clk); while (in_full);
  endtask

  // Hold off the sender until every predicted result has been popped.
  // results_owed is registered in the checker, so the value read after an
  // edge already counts the transaction accepted at the edge before.
  task automatic drain_results();
    in_push <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  initial begin
    logic [ADDR_W-1:0] addr;
    logic              op;
    int                issued;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero memory after reset, every alignment, last-word wrap,
    // empty mask, and the write result.
    issue_access(OP_READ,  12'd0,    32'h0,        4'h0);
    issue_access(OP_READ,  12'd4095, 32'h0,        4'h0);
    issue_access(OP_WRITE, 12'd0,    32'h11223344, 4'hf);  // aligned, word 1 untouched
    issue_access(OP_READ,  12'd0,    32'h0,        4'h0);
    issue_access(OP_READ,  12'd1,    32'h0,        4'h0);
    issue_access(OP_READ,  12'd2,    32'h0,        4'h0);
    issue_access(OP_READ,  12'd3,    32'h0,        4'h0);
    issue_access(OP_WRITE, 12'd5,    32'haabbccdd, 4'hf);  // offset 1, splits
    issue_access(OP_WRITE, 12'd10,   32'hffffffff, 4'h5);  // offset 2, sparse mask
    issue_access(OP_WRITE, 12'd15,   32'h5a5a5a5a, 4'hf);  // offset 3
    issue_access(OP_WRITE, 12'd20,   32'hffffffff, 4'h0);  // empty mask
    issue_access(OP_READ,  12'd20,   32'h0,        4'h0);
    issue_access(OP_READ,  12'd4,    32'h0,        4'h0);
    issue_access(OP_READ,  12'd8,    32'h0,        4'h0);
    issue_access(OP_READ,  12'd12,   32'h0,        4'h0);
    issue_access(OP_READ,  12'd16,   32'h0,        4'h0);
    issue_access(OP_WRITE, 12'd4095, 32'hdeadbeef, 4'hf);  // wraps into word 0
    issue_access(OP_READ,  12'd4092, 32'h0,        4'h0);
    issue_access(OP_READ,  12'd4094, 32'h0,        4'h0);
    issue_access(OP_READ,  12'd4095, 32'h0,        4'h0);
    issue_access(OP_READ,  12'd0,    32'h0,        4'h0);
    issue_access(OP_WRITE, 12'd4092, 32'hffffffff, 4'hf);  // aligned last word
    issue_access(OP_READ,  12'd4093, 32'h0,        4'h0);
    issue_access(OP_READ,  12'd0,    32'h0,        4'h0);

    // Let everything drain before the random part starts.
    drain_results();

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      // steady stretch with no gaps on either side
      steady_flow <= (issued >= 200 && issued < 350);
      if (issued == 400) drain_results();
      // Half of the addresses land in two small windows, one of them across the
      // wrap point, so reads keep hitting bytes that were just written.
      case ($urandom_range(3))
        0:       addr = ADDR_W'($urandom_range(63));
        1:       addr = ADDR_W'($urandom_range(4095, 4032));
        default: addr = ADDR_W'($urandom_range(4095));
      endcase
      op = $urandom_range(1) ? OP_WRITE : OP_READ;
      issue_access(op, addr, $urandom, MASK_W'($urandom_range(15)));
      issued++;
      // write then read back nearby: the byte merge across two words
      if (op == OP_WRITE && $urandom_range(99) < 40) begin
        issue_access(OP_READ, ADDR_W'(addr + $urandom_range(3) - 12'd1), $urandom,
                     MASK_W'($urandom_range(15)));
        issued++;
      end
    end
    steady_flow <= 1'b0;

    // Wait for the last results, then keep watching for strays.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/mbm_pkg.sv
src/mbm_front.sv
src/mbm_cmd_queue.sv
src/mbm_back.sv
src/misaligned_byte_mask_word_memory.sv
verif/mbm_checker.sv
verif/tb.sv
